// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the merge block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define KWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KWM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define KWM_ASSERT(lbl, prop, msg)
`define KWM_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hdl/kwm_pkg.sv -----
// Shared constants, codes and state type of the k-way stream merge.
package kwm_pkg;

  localparam int NUM_SOURCES_DEF  = 8;
  localparam int KEY_BITS_DEF     = 63;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int ACTIVE_RST       = 8;

  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_DONE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

endpackage

// ----- hdl/kwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/kwm_scan.sv -----
// Sequential minimum search over the head memory, one entry per cycle.
module kwm_scan #(
  parameter int NUM_SOURCES  = kwm_pkg::NUM_SOURCES_DEF,
  parameter int KEY_BITS     = kwm_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = kwm_pkg::PAYLOAD_BITS_DEF,
  localparam int SRC_W       = $clog2(NUM_SOURCES)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SRC_W-1:0]        last_idx,
  input  logic [NUM_SOURCES-1:0]  head_valid,
  output logic [SRC_W-1:0]        rd_addr,
  input  logic [KEY_BITS-1:0]     rd_key,
  input  logic [PAYLOAD_BITS-1:0] rd_payload,
  output logic                    done,
  output logic [KEY_BITS-1:0]     best_key,
  output logic [PAYLOAD_BITS-1:0] best_payload,
  output logic [SRC_W-1:0]        best_src
);

  logic                    busy_r, busy_nxt;
  logic [SRC_W-1:0]        scan_r, scan_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic                    cmp_last_r, cmp_last_nxt;
  logic [SRC_W-1:0]        cmp_src_r, cmp_src_nxt;
  logic                    any_r, any_nxt;
  logic                    done_r, done_nxt;
  logic [KEY_BITS-1:0]     best_key_r, best_key_nxt;
  logic [PAYLOAD_BITS-1:0] best_pay_r, best_pay_nxt;
  logic [SRC_W-1:0]        best_src_r, best_src_nxt;

  always_comb begin
    busy_nxt     = busy_r;
    scan_nxt     = scan_r;
    cmp_vld_nxt  = 1'b0;
    cmp_last_nxt = 1'b0;
    cmp_src_nxt  = scan_r;
    any_nxt      = any_r;
    best_key_nxt = best_key_r;
    best_pay_nxt = best_pay_r;
    best_src_nxt = best_src_r;
    done_nxt     = cmp_vld_r && cmp_last_r;
    if (start) begin
      busy_nxt = 1'b1;
      scan_nxt = '0;
      any_nxt  = 1'b0;
    end else if (busy_r) begin
      cmp_vld_nxt  = 1'b1;
      cmp_last_nxt = (scan_r == last_idx);
      if (scan_r == last_idx) begin
        busy_nxt = 1'b0;
      end else begin
        scan_nxt = scan_r + SRC_W'(1);
      end
    end
    // later index wins on equal keys
    if (cmp_vld_r && head_valid[cmp_src_r] && (!any_r || rd_key <= best_key_r)) begin
      any_nxt      = 1'b1;
      best_key_nxt = rd_key;
      best_pay_nxt = rd_payload;
      best_src_nxt = cmp_src_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      cmp_vld_r  <= 1'b0;
      cmp_last_r <= 1'b0;
      done_r     <= 1'b0;
      any_r      <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      cmp_last_r <= cmp_last_nxt;
      done_r     <= done_nxt;
      any_r      <= any_nxt;
    end
    scan_r     <= scan_nxt;
    cmp_src_r  <= cmp_src_nxt;
    best_key_r <= best_key_nxt;
    best_pay_r <= best_pay_nxt;
    best_src_r <= best_src_nxt;
  end

  assign rd_addr      = scan_r;
  assign done         = done_r;
  assign best_key     = best_key_r;
  assign best_payload = best_pay_r;
  assign best_src     = best_src_r;

endmodule

// ----- hdl/kway_ordered_stream_merge.sv -----
// Top level of the k-way ordered stream merge.
//
//   port group | direction | transfer when      | carries
//   in_*       | input     | in_valid & !stall  | source event or exhaustion
//   out_*      | output    | out_valid & !stall | merged event, need mask, done
//   cfg_*      | input     | cfg_wr_en          | active source count
//
// An item without emission goes from ST_IDLE to ST_OUT; an item that emits first passes
// through ST_SCAN, which reads the head RAM one entry per cycle for each active source.
// A result waiting on out_stall does not block the next input transfer.
// Synchronous active-low reset clears all heads and finished marks; no RAM clear.
// Head RAM entries only enter the minimum while the matching valid bit is set.
`include "assert_macros.svh"

module kway_ordered_stream_merge #(
  parameter int NUM_SOURCES  = kwm_pkg::NUM_SOURCES_DEF,
  parameter int KEY_BITS     = kwm_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = kwm_pkg::PAYLOAD_BITS_DEF,
  localparam int SRC_W       = $clog2(NUM_SOURCES),
  localparam int CNT_W       = $clog2(NUM_SOURCES + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CNT_W-1:0]        cfg_active_sources,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [SRC_W-1:0]        in_source_index,
  input  logic [KEY_BITS-1:0]     in_event_key,
  input  logic [PAYLOAD_BITS-1:0] in_event_payload,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_emitted,
  output logic [KEY_BITS-1:0]     out_key,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic [SRC_W-1:0]        out_source,
  output logic [NUM_SOURCES-1:0]  out_need_mask,
  output logic                    out_all_done
);

  localparam int RAM_W   = KEY_BITS + PAYLOAD_BITS;
  localparam int CNT_RST = (kwm_pkg::ACTIVE_RST < NUM_SOURCES) ?
                           kwm_pkg::ACTIVE_RST : NUM_SOURCES;

  kwm_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [NUM_SOURCES-1:0]  head_valid_r, head_valid_nxt;
  logic [NUM_SOURCES-1:0]  fin_r, fin_nxt;
  logic                    emit_r, emit_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_emit_r, out_emit_nxt;
  logic [KEY_BITS-1:0]     out_key_r, out_key_nxt;
  logic [PAYLOAD_BITS-1:0] out_pay_r, out_pay_nxt;
  logic [SRC_W-1:0]        out_src_r, out_src_nxt;
  logic [NUM_SOURCES-1:0]  out_need_r, out_need_nxt;
  logic                    out_done_r, out_done_nxt;

  logic                    accept;
  logic                    out_free;
  logic                    load;
  logic                    scan_start;
  logic                    src_ok;
  logic                    wr_ok;
  logic                    emit_upd;
  logic [NUM_SOURCES-1:0]  act_mask;
  logic [NUM_SOURCES-1:0]  valid_upd;
  logic [NUM_SOURCES-1:0]  fin_upd;
  logic [NUM_SOURCES-1:0]  clr_mask;
  logic [NUM_SOURCES-1:0]  valid_after;
  logic [NUM_SOURCES-1:0]  need_mask;
  logic                    ram_we;
  logic [SRC_W-1:0]        rd_addr;
  logic [RAM_W-1:0]        rd_data;
  logic                    scan_done;
  logic [KEY_BITS-1:0]     best_key;
  logic [PAYLOAD_BITS-1:0] best_payload;
  logic [SRC_W-1:0]        best_src;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      act_mask[i] = (CNT_W'(i) < cnt_r);
    end
  end

  // apply the incoming item to the marks
  always_comb begin
    src_ok    = (CNT_W'(in_source_index) < cnt_r);
    wr_ok     = src_ok && (in_req_type == kwm_pkg::REQ_EVENT) &&
                !fin_r[in_source_index] && !head_valid_r[in_source_index];
    valid_upd = head_valid_r;
    fin_upd   = fin_r;
    if (wr_ok) begin
      valid_upd[in_source_index] = 1'b1;
    end
    if (src_ok && (in_req_type == kwm_pkg::REQ_DONE)) begin
      fin_upd[in_source_index] = 1'b1;
    end
    emit_upd = |(valid_upd & act_mask) && !(|(act_mask & ~valid_upd & ~fin_upd));
  end

  // marks after the emitted head leaves
  always_comb begin
    clr_mask           = '0;
    clr_mask[best_src] = emit_r;
    valid_after        = head_valid_r & ~clr_mask;
    need_mask          = act_mask & ~fin_r & ~valid_after;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kwm_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = emit_upd ? kwm_pkg::ST_SCAN : kwm_pkg::ST_OUT;
        end
      end
      kwm_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = kwm_pkg::ST_OUT;
        end
      end
      kwm_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = kwm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kwm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    scan_start = 1'b0;
    ram_we     = 1'b0;
    load       = 1'b0;
    case (state_r)
      kwm_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        scan_start = in_valid && emit_upd;
        ram_we     = in_valid && wr_ok;
      end
      kwm_pkg::ST_SCAN: begin
        in_stall = 1'b1;
      end
      kwm_pkg::ST_OUT: begin
        load = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    head_valid_nxt = head_valid_r;
    fin_nxt        = fin_r;
    emit_nxt       = emit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_emit_nxt   = out_emit_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_src_nxt    = out_src_r;
    out_need_nxt   = out_need_r;
    out_done_nxt   = out_done_r;
    if (cfg_wr_en) begin
      if (cfg_active_sources == '0) begin
        cnt_nxt = CNT_W'(1);
      end else if (cfg_active_sources > CNT_W'(NUM_SOURCES)) begin
        cnt_nxt = CNT_W'(NUM_SOURCES);
      end else begin
        cnt_nxt = cfg_active_sources;
      end
    end
    if (accept) begin
      head_valid_nxt = valid_upd;
      fin_nxt        = fin_upd;
      emit_nxt       = emit_upd;
    end
    if (load) begin
      head_valid_nxt = valid_after;
      out_valid_nxt  = 1'b1;
      out_emit_nxt   = emit_r;
      out_key_nxt    = emit_r ? best_key : '0;
      out_pay_nxt    = emit_r ? best_payload : '0;
      out_src_nxt    = emit_r ? best_src : '0;
      out_need_nxt   = need_mask;
      out_done_nxt   = !(|(act_mask & ~(fin_r & ~valid_after)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kwm_pkg::ST_IDLE;
      cnt_r        <= CNT_W'(CNT_RST);
      head_valid_r <= '0;
      fin_r        <= '0;
      emit_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      head_valid_r <= head_valid_nxt;
      fin_r        <= fin_nxt;
      emit_r       <= emit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_emit_r <= out_emit_nxt;
    out_key_r  <= out_key_nxt;
    out_pay_r  <= out_pay_nxt;
    out_src_r  <= out_src_nxt;
    out_need_r <= out_need_nxt;
    out_done_r <= out_done_nxt;
  end

  kwm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_SOURCES)
  ) u_head_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_source_index),
    .wdata ({in_event_key, in_event_payload}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  kwm_scan #(
    .NUM_SOURCES  (NUM_SOURCES),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (scan_start),
    .last_idx     (SRC_W'(cnt_r - CNT_W'(1))),
    .head_valid   (head_valid_r),
    .rd_addr      (rd_addr),
    .rd_key       (rd_data[RAM_W-1 -: KEY_BITS]),
    .rd_payload   (rd_data[PAYLOAD_BITS-1:0]),
    .done         (scan_done),
    .best_key     (best_key),
    .best_payload (best_payload),
    .best_src     (best_src)
  );

  assign out_valid     = out_valid_r;
  assign out_emitted   = out_emit_r;
  assign out_key       = out_key_r;
  assign out_payload   = out_pay_r;
  assign out_source    = out_src_r;
  assign out_need_mask = out_need_r;
  assign out_all_done  = out_done_r;

  `KWM_NEVER(a_wr_full_slot, ram_we && head_valid_r[in_source_index], "write into held slot")
  `KWM_ASSERT(a_emit_held, load && emit_r |-> head_valid_r[best_src], "emit of empty slot")
  `KWM_ASSERT(a_done_in_scan, scan_done |-> state_r == kwm_pkg::ST_SCAN, "scan done outside scan")
  `KWM_ASSERT(a_need_after_emit, out_valid_r && out_emit_r |->
              out_need_r[out_src_r] || fin_r[out_src_r], "emitted source not requested")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the k-way ordered stream merge.
module tb_top;

  localparam int NS = kwm_pkg::NUM_SOURCES_DEF;
  localparam int KW = kwm_pkg::KEY_BITS_DEF;
  localparam int PW = kwm_pkg::PAYLOAD_BITS_DEF;
  localparam int SW = $clog2(NS);
  localparam int CW = $clog2(NS + 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 125;
  localparam int DIR_ROWS = 24;
  localparam logic REQ_EVENT = kwm_pkg::REQ_EVENT;
  localparam logic REQ_DONE  = kwm_pkg::REQ_DONE;

  typedef struct packed {
    logic          emitted;
    logic [KW-1:0] key;
    logic [PW-1:0] payload;
    logic [SW-1:0] source;
    logic [NS-1:0] need;
    logic          done;
  } merge_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [CW-1:0] cfg;
    logic          req;
    logic [SW-1:0] src;
    logic [KW-1:0] key;
    logic [PW-1:0] pay;
    logic          typed;
    merge_out_t    want;
  } dir_row_t;

  localparam logic [KW-1:0] KMAX = '1;
  localparam logic [KW-1:0] K55  = 63'h5555_5555_5555_5555;
  localparam logic [KW-1:0] K2A  = 63'h2AAA_AAAA_AAAA_AAAA;
  localparam merge_out_t NONE     = '0;
  localparam merge_out_t WAIT_1   = '{1'b0, '0, '0, '0, 8'h02, 1'b0};
  localparam merge_out_t WAIT_ALL = '{1'b0, '0, '0, '0, 8'h7F, 1'b0};

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_CFG,  4'd2,  REQ_EVENT, 3'd0, '0, '0, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd0, KMAX, 32'hFFFF_FFFF, 1'b1, WAIT_1},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd1, '0, '0, 1'b1, '{1'b1, '0, '0, 3'd1, 8'h02, 1'b0}},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd1, KMAX, '0, 1'b1,
      '{1'b1, KMAX, '0, 3'd1, 8'h02, 1'b0}},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd0, 63'd5, 32'd1, 1'b1, WAIT_1},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd5, K2A, 32'h5555_5555, 1'b1, WAIT_1},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd1, K55, 32'hAAAA_AAAA, 1'b0, NONE},
    '{ROW_CFG,  4'd0,  REQ_EVENT, 3'd0, '0, '0, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd3, K2A, 32'h5555_5555, 1'b1,
      '{1'b1, KMAX, 32'hFFFF_FFFF, 3'd0, 8'h01, 1'b0}},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd0, K2A, 32'h5555_5555, 1'b0, NONE},
    '{ROW_CFG,  4'd15, REQ_EVENT, 3'd0, '0, '0, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd7, 63'd3, 32'h0000_FFFF, 1'b1, WAIT_ALL},
    '{ROW_ITEM, 4'd0,  REQ_DONE,  3'd7, '0, '0, 1'b1, WAIT_ALL},
    '{ROW_ITEM, 4'd0,  REQ_DONE,  3'd7, '0, '0, 1'b1, WAIT_ALL},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd7, 63'd1, 32'h1, 1'b1, WAIT_ALL},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd0, 63'd7, 32'h1234_5678, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd1, 63'd9, 32'h8765_4321, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd2, 63'd3, 32'h0F0F_0F0F, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd3, 63'd12, 32'hF0F0_F0F0, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd4, KMAX, 32'h0, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd5, 63'h4000_0000_0000_0000, 32'h3C3C_3C3C, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd6, 63'd5, 32'hC3C3_C3C3, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_EVENT, 3'd7, 63'd0, 32'h7777_7777, 1'b0, NONE},
    '{ROW_ITEM, 4'd0,  REQ_DONE,  3'd7, '0, '0, 1'b0, NONE}
  };

  localparam logic [CW-1:0] PHASE_CFG [10] = '{
    4'd8, 4'd3, 4'd1, 4'd12, 4'd5, 4'd2, 4'd0, 4'd6, 4'd15, 4'd4
  };

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_wr_en = 1'b0;
  logic [CW-1:0] cfg_active_sources = CW'(kwm_pkg::ACTIVE_RST);
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_req_type = REQ_EVENT;
  logic [SW-1:0] in_source_index = '0;
  logic [KW-1:0] in_event_key = '0;
  logic [PW-1:0] in_event_payload = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_emitted;
  logic [KW-1:0] out_key;
  logic [PW-1:0] out_payload;
  logic [SW-1:0] out_source;
  logic [NS-1:0] out_need_mask;
  logic          out_all_done;

  // predictor state
  logic [KW-1:0] slot_key [NS];
  logic [PW-1:0] slot_payload [NS];
  logic [NS-1:0] slot_full = '0;
  logic [NS-1:0] src_exhausted = '0;
  logic [CW-1:0] count_reg = CW'(kwm_pkg::ACTIVE_RST);

  merge_out_t merge_due_q [$];
  merge_out_t oldest;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int xfer_cnt = 0;
  int result_cnt = 0;
  int merged_cnt = 0;
  int cfg_cnt = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  kway_ordered_stream_merge dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_active_sources (cfg_active_sources),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_source_index    (in_source_index),
    .in_event_key       (in_event_key),
    .in_event_payload   (in_event_payload),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_emitted        (out_emitted),
    .out_key            (out_key),
    .out_payload        (out_payload),
    .out_source         (out_source),
    .out_need_mask      (out_need_mask),
    .out_all_done       (out_all_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int live_sources();
    if (count_reg == '0) return 1;
    if (int'(count_reg) > NS) return NS;
    return int'(count_reg);
  endfunction

  function automatic logic [NS-1:0] active_mask();
    logic [NS-1:0] m;
    int i;
    m = '0;
    for (i = 0; i < live_sources(); i++) m[i] = 1'b1;
    return m;
  endfunction

  function automatic logic [SW-1:0] pick_source(logic [NS-1:0] mask);
    int i;
    int sel;
    sel = $urandom_range(0, $countones(mask) - 1);
    for (i = 0; i < NS; i++) begin
      if (mask[i]) begin
        if (sel == 0) return SW'(i);
        sel--;
      end
    end
    return '0;
  endfunction

  function automatic merge_out_t merge_predict(logic req, logic [SW-1:0] src,
                                               logic [KW-1:0] key, logic [PW-1:0] pay);
    merge_out_t res;
    int n;
    int i;
    int best;
    bit any;
    bit ready;
    res = '0;
    n = live_sources();
    best = 0;
    any = 1'b0;
    ready = 1'b1;
    if (int'(src) < n) begin
      if (req == REQ_EVENT) begin
        if (!src_exhausted[src] && !slot_full[src]) begin
          slot_key[src] = key;
          slot_payload[src] = pay;
          slot_full[src] = 1'b1;
        end
      end else begin
        src_exhausted[src] = 1'b1;
      end
    end
    // ties go to the higher source
    for (i = 0; i < n; i++) begin
      if (slot_full[i]) begin
        if (!any || slot_key[i] <= slot_key[best]) best = i;
        any = 1'b1;
      end else if (!src_exhausted[i]) begin
        ready = 1'b0;
      end
    end
    if (any && ready) begin
      slot_full[best] = 1'b0;
      res.emitted = 1'b1;
      res.key = slot_key[best];
      res.payload = slot_payload[best];
      res.source = SW'(best);
    end
    res.done = 1'b1;
    for (i = 0; i < n; i++) begin
      if (!src_exhausted[i] || slot_full[i]) res.done = 1'b0;
      if (!src_exhausted[i] && !slot_full[i]) res.need[i] = 1'b1;
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s at result %0d: got %h, want %h", what, result_cnt, got, want);
    mismatch_cnt++;
  endtask

  task automatic send_merge_item(logic req, logic [SW-1:0] src, logic [KW-1:0] key,
                                 logic [PW-1:0] pay, logic typed, merge_out_t want);
    merge_out_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_source_index  <= src;
    in_event_key     <= key;
    in_event_payload <= pay;
    do @(posedge clk); while (in_stall);
    pred = merge_predict(req, src, key, pay);
    merge_due_q.insert(merge_due_q.size(), typed ? want : pred);
    xfer_cnt++;
  endtask

  task automatic drain_merges();
    in_valid <= 1'b0;
    while (merge_due_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_active_sources(logic [CW-1:0] value);
    drain_merges();
    cfg_wr_en          <= 1'b1;
    cfg_active_sources <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    count_reg = value;
    cfg_cnt++;
  endtask

  task automatic run_phase(int max_items, logic closing);
    logic [NS-1:0] need;
    logic [NS-1:0] live;
    logic [SW-1:0] src;
    logic          req;
    logic [63:0]   raw;
    int k;
    int tail;
    tail = 0;
    for (k = 0; k < max_items; k++) begin
      live = active_mask();
      need = ~src_exhausted & ~slot_full & live;
      if (closing && ((~src_exhausted | slot_full) & live) == '0) begin
        if (tail == 6) break;
        tail++;
      end
      if ($urandom_range(0, 99) < 82) begin
        if (need == '0) begin
          if ((src_exhausted & live) != '0) begin
            req = REQ_DONE;
            src = pick_source(src_exhausted & live);
          end else begin
            req = REQ_EVENT;
            src = pick_source(live);
          end
        end else if (closing && $urandom_range(0, 9) == 0) begin
          req = REQ_DONE;
          src = pick_source(~src_exhausted & live);
        end else begin
          req = REQ_EVENT;
          src = pick_source(need);
        end
      end else begin
        src = SW'($urandom_range(0, NS - 1));
        req = ($urandom_range(0, 1) == 0) ? REQ_EVENT : REQ_DONE;
        // keep sources 0 and 1 alive until the closing phase
        if (req == REQ_DONE && !closing && !src_exhausted[src] &&
            (src < 2 || $urandom_range(0, 29) != 0))
          req = REQ_EVENT;
      end
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: raw = 64'(raw[2:0]);
        1: raw = 64'(raw[19:0]);
        2: raw = ~64'(raw[1:0]);
        default: ;
      endcase
      send_merge_item(req, src, raw[KW-1:0], PW'($urandom), 1'b0, NONE);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      result_cnt++;
      if (merge_due_q.size() == 0) begin
        flag_mismatch("unexpected result", 64'(out_key), 64'(0));
      end else begin
        oldest = merge_due_q.pop_front();
        if (out_emitted !== oldest.emitted)
          flag_mismatch("emitted", 64'(out_emitted), 64'(oldest.emitted));
        if (out_key !== oldest.key)
          flag_mismatch("key", 64'(out_key), 64'(oldest.key));
        if (out_payload !== oldest.payload)
          flag_mismatch("payload", 64'(out_payload), 64'(oldest.payload));
        if (out_source !== oldest.source)
          flag_mismatch("source", 64'(out_source), 64'(oldest.source));
        if (out_need_mask !== oldest.need)
          flag_mismatch("need_mask", 64'(out_need_mask), 64'(oldest.need));
        if (out_all_done !== oldest.done)
          flag_mismatch("all_done", 64'(out_all_done), 64'(oldest.done));
        if (out_emitted === 1'b1) merged_cnt++;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             merge_due_q.size());
    $display("[kway_ordered_stream_merge] ERROR");
    $finish;
  end

  initial begin
    int r;
    int p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        set_active_sources(DIR_TAB[r].cfg);
      end else begin
        send_merge_item(DIR_TAB[r].req, DIR_TAB[r].src, DIR_TAB[r].key, DIR_TAB[r].pay,
                        DIR_TAB[r].typed, DIR_TAB[r].want);
      end
    end
    for (p = 0; p < 10; p++) begin
      send_idle_pct = (p % 4 == 1) ? 71 : (p % 4 == 3) ? 38 : 0;
      stall_pct     = (p % 4 == 2) ? 71 : (p % 4 == 3) ? 38 : 0;
      set_active_sources(PHASE_CFG[p]);
      run_phase(PHASE_ITEMS, 1'b0);
    end
    // exhaust every source and drain the remaining heads
    send_idle_pct = 38;
    stall_pct = 38;
    set_active_sources(CW'(NS));
    run_phase(400, 1'b1);
    drain_merges();
    repeat (16) @(posedge clk);
    if (merge_due_q.size() != 0)
      flag_mismatch("results never arrived", 64'(merge_due_q.size()), 64'(0));
    $display("covered %0d input transfers, %0d merged events, %0d source-count writes",
             xfer_cnt, merged_cnt, cfg_cnt);
    $display("counts 0..15 incl. clamped values, ties, drops, exhaustion and drain");
    if (mismatch_cnt == 0) begin
      $display("[kway_ordered_stream_merge] OK");
    end else begin
      $display("[kway_ordered_stream_merge] ERROR");
    end
    $finish;
  end

endmodule
